@@ src/assert_macros.svh @@
// assertion helpers shared by sfs_step and sprite_frame_sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same check, evaluated also during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ src/sfs_pkg.sv @@
`timescale 1ns / 1ps

package sfs_pkg;

  // default parameter values
  localparam int unsigned MAX_FRAMES_DEF = 256;
  localparam int unsigned TICK_BITS_DEF  = 16;

  // texel coordinate range
  localparam logic [11:0] TEXEL_MAX = 12'hFFF;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_MODE          = 3'd0,
    CFG_TICK_INTERVAL = 3'd1,
    CFG_FRAME_COUNT   = 3'd2,
    CFG_FIRST_LEFT    = 3'd3,
    CFG_FRAME_WIDTH   = 3'd4,
    CFG_FRAME_GAP     = 3'd5,
    CFG_TOP_ROW       = 3'd6,
    CFG_FRAME_HEIGHT  = 3'd7
  } cfg_idx_e;

  // animation modes, the unused code behaves as step right
  typedef enum logic [1:0] {
    MODE_RIGHT = 2'd0,
    MODE_SWING = 2'd1,
    MODE_LEFT  = 2'd2
  } mode_e;

  // configuration register file
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] tick_interval;
    logic [8:0]  frame_count;
    logic [11:0] first_left;
    logic [11:0] frame_width;
    logic [11:0] frame_gap;
    logic [11:0] top_row;
    logic [11:0] frame_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    mode:          MODE_RIGHT,
    tick_interval: 16'd1,
    frame_count:   9'd1,
    first_left:    12'd0,
    frame_width:   TEXEL_MAX,
    frame_gap:     12'd0,
    top_row:       TEXEL_MAX,
    frame_height:  TEXEL_MAX
  };

  // frame rectangle for one result
  typedef struct packed {
    logic [11:0] left_edge;
    logic [11:0] right_edge;
    logic [12:0] bottom_edge;
    logic [11:0] top_edge;
  } rect_t;

endpackage

@@ src/sfs_step.sv @@
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sfs_step #(
  parameter int unsigned MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF,
  parameter int unsigned TICK_BITS  = sfs_pkg::TICK_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sfs_pkg::cfg_t                 cfg_i,
  input  logic                          accept_i,
  input  logic                          restart_i,
  output logic [$clog2(MAX_FRAMES)-1:0] frame_o,
  output logic                          changed_o
);
  import sfs_pkg::*;

  localparam int unsigned FB = $clog2(MAX_FRAMES);
  localparam int unsigned NW = FB + 1;
  localparam int unsigned CW = FB + 2;
  localparam int unsigned IW = (TICK_BITS > 16) ? TICK_BITS : 16;
  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

  logic [TICK_BITS-1:0] tick_count_q, tick_count_d;
  logic [FB-1:0]        frame_now_q, frame_now_d;
  logic                 moving_left_q, moving_left_d;

  logic [NW-1:0]        n_eff;
  logic [CW-1:0]        f_ext, n_ext, nm1, cand;
  logic [TICK_BITS-1:0] tick_inc;
  logic [15:0]          ivl;
  logic                 advance;

  // effective frame count, clamped to 1 .. MAX_FRAMES
  always_comb begin
    if (cfg_i.frame_count == 9'd0) begin
      n_eff = NW'(1);
    end else if (32'(cfg_i.frame_count) > 32'(MAX_FRAMES)) begin
      n_eff = NW'(MAX_FRAMES);
    end else begin
      n_eff = NW'(cfg_i.frame_count);
    end
  end

  assign f_ext = CW'(frame_now_q);
  assign n_ext = CW'(n_eff);
  assign nm1   = n_ext - CW'(1);

  // tick counter, saturating at its maximum
  assign tick_inc = (tick_count_q == TICK_MAX) ? tick_count_q : tick_count_q + TICK_BITS'(1);
  assign ivl      = (cfg_i.tick_interval == 16'd0) ? 16'd1 : cfg_i.tick_interval;
  assign advance  = (IW'(tick_inc) >= IW'(ivl)) || (tick_inc == TICK_MAX);

  // next state for one transaction
  always_comb begin
    tick_count_d  = tick_count_q;
    frame_now_d   = frame_now_q;
    moving_left_d = moving_left_q;
    changed_o     = 1'b0;
    cand          = '0;
    if (restart_i) begin
      tick_count_d = '0;
      changed_o    = 1'b1;
      if (cfg_i.mode == MODE_LEFT) begin
        frame_now_d   = FB'(nm1);
        moving_left_d = 1'b1;
      end else begin
        frame_now_d   = '0;
        moving_left_d = 1'b0;
      end
    end else begin
      tick_count_d = tick_inc;
      if (advance) begin
        tick_count_d = '0;
        changed_o    = 1'b1;
        if (!moving_left_q && (f_ext + CW'(1) < n_ext)) begin
          frame_now_d = FB'(f_ext + CW'(1));
        end else if (moving_left_q && (f_ext != '0) && (f_ext - CW'(1) < n_ext)) begin
          frame_now_d = FB'(f_ext - CW'(1));
        end else if (cfg_i.mode == MODE_SWING) begin
          // reverse at the edge and step back, clamped into range
          moving_left_d = !moving_left_q;
          if (!moving_left_q) begin
            cand = (f_ext == '0) ? '0 : f_ext - CW'(1);
          end else begin
            cand = f_ext + CW'(1);
          end
          frame_now_d = (cand > nm1) ? FB'(nm1) : FB'(cand);
        end else if (cfg_i.mode == MODE_LEFT) begin
          frame_now_d   = FB'(nm1);
          moving_left_d = 1'b1;
        end else begin
          frame_now_d   = '0;
          moving_left_d = 1'b0;
        end
      end
    end
  end

  // state registers, updated once per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q  <= '0;
      frame_now_q   <= '0;
      moving_left_q <= 1'b0;
    end else if (accept_i) begin
      tick_count_q  <= tick_count_d;
      frame_now_q   <= frame_now_d;
      moving_left_q <= moving_left_d;
    end
  end

  assign frame_o = frame_now_d;

  `ASSERT_CLK(a_restart_clears_ticks, accept_i && restart_i |=> tick_count_q == '0,
    "restart did not clear the tick counter")
  `ASSERT_CLK(a_restart_frame_zero,
    accept_i && restart_i && cfg_i.mode != MODE_LEFT |=> frame_now_q == '0 && !moving_left_q,
    "restart did not return to frame zero moving right")
  `ASSERT_CLK(a_idle_holds_state,
    !accept_i |=> $stable(frame_now_q) && $stable(moving_left_q) && $stable(tick_count_q),
    "animation state moved without a transaction")

endmodule

@@ src/sfs_rect.sv @@
`timescale 1ns / 1ps

module sfs_rect #(
  parameter int unsigned MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
  input  sfs_pkg::cfg_t                 cfg_i,
  input  logic [$clog2(MAX_FRAMES)-1:0] frame_i,
  output sfs_pkg::rect_t                rect_o
);
  import sfs_pkg::*;

  localparam int unsigned FB = $clog2(MAX_FRAMES);
  localparam int unsigned LW = FB + 14;

  logic [12:0]   pitch;
  logic [LW-1:0] left_full, right_full;

  // frame offset on the sheet: one add for the pitch, one multiply, then two adds
  assign pitch      = {1'b0, cfg_i.frame_width} + {1'b0, cfg_i.frame_gap};
  assign left_full  = LW'(frame_i) * LW'(pitch) + LW'(cfg_i.first_left);
  assign right_full = left_full + LW'(cfg_i.frame_width);

  // saturate both horizontal edges at the sheet limit
  always_comb begin
    rect_o.left_edge   = (left_full > LW'(TEXEL_MAX)) ? TEXEL_MAX : left_full[11:0];
    rect_o.right_edge  = (right_full > LW'(TEXEL_MAX)) ? TEXEL_MAX : right_full[11:0];
    rect_o.bottom_edge = {1'b0, cfg_i.top_row} - {1'b0, cfg_i.frame_height};
    rect_o.top_edge    = cfg_i.top_row;
  end

endmodule

@@ src/sprite_frame_sequencer.sv @@
`timescale 1ns / 1ps
// an accepted input transaction reaches the master side through stage one and the result register
// throughput: one transaction per cycle unless the master side stalls, stage one holds the
//   frame step, stage two the multiply that places the frame on the sheet
// reset: asynchronous active low; clears tick count, frame, direction, stage valids and
//   returns the configuration registers to their defaults

`include "assert_macros.svh"

module sprite_frame_sequencer #(
  parameter int unsigned MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF,
  parameter int unsigned TICK_BITS  = sfs_pkg::TICK_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [7:0] frame_index, [8] frame_changed,
                                      // [20:9] left_edge, [32:21] right_edge,
                                      // [45:33] bottom_edge, [57:46] top_edge, [63:58] zero
);
  import sfs_pkg::*;

  localparam int unsigned FB = $clog2(MAX_FRAMES);

  cfg_t          cfg_q;
  logic          accept, s2_ready;
  logic [FB-1:0] step_frame;
  logic          step_changed;
  logic          s1_valid_q;
  logic [FB-1:0] s1_frame_q;
  logic          s1_changed_q;
  rect_t         rect;
  logic          m_valid_q;
  logic [7:0]    m_index_q;
  logic          m_changed_q;
  rect_t         m_rect_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:          cfg_q.mode          <= cfg_wdata_i[1:0];
        CFG_TICK_INTERVAL: cfg_q.tick_interval <= cfg_wdata_i;
        CFG_FRAME_COUNT:   cfg_q.frame_count   <= cfg_wdata_i[8:0];
        CFG_FIRST_LEFT:    cfg_q.first_left    <= cfg_wdata_i[11:0];
        CFG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_wdata_i[11:0];
        CFG_FRAME_GAP:     cfg_q.frame_gap     <= cfg_wdata_i[11:0];
        CFG_TOP_ROW:       cfg_q.top_row       <= cfg_wdata_i[11:0];
        CFG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg_wdata_i[11:0];
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  // pipeline flow control
  assign s2_ready      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s2_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // frame step and animation state
  sfs_step #(
    .MAX_FRAMES(MAX_FRAMES),
    .TICK_BITS (TICK_BITS)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .restart_i(s_axis_tdata[0]),
    .frame_o  (step_frame),
    .changed_o(step_changed)
  );

  // stage one register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_frame_q   <= step_frame;
      s1_changed_q <= step_changed;
    end
  end

  // frame rectangle from the registered frame
  sfs_rect #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_rect (
    .cfg_i  (cfg_q),
    .frame_i(s1_frame_q),
    .rect_o (rect)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s2_ready) begin
      m_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      m_index_q   <= 8'(s1_frame_q);
      m_changed_q <= s1_changed_q;
      m_rect_q    <= rect;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, m_rect_q.top_edge, m_rect_q.bottom_edge,
                          m_rect_q.right_edge, m_rect_q.left_edge, m_changed_q, m_index_q};

  `ASSERT_CLK(a_stall_blocks_input, s1_valid_q && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready,
    "input taken while both stages are full and stalled")
  `ASSERT_CLK(a_accept_fills_stage, accept |=> s1_valid_q,
    "accepted transaction did not reach stage one")

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import sfs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 20000;
  localparam int unsigned REPORT_CAP  = 100;
  // mode code with no name in the package, behaves as step right
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [TICK_BITS_DEF-1:0] TICK_TOP = '1;

  // one result transaction, fields as they leave the block
  typedef struct packed {
    logic [7:0]  frame_index;
    logic        frame_changed;
    logic [11:0] left_edge;
    logic [11:0] right_edge;
    logic [12:0] bottom_edge;
    logic [11:0] top_edge;
    logic [5:0]  pad;
  } sprite_view_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [0] restart, [7:1] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // [7:0] frame_index, [8] frame_changed, [20:9] left_edge,
                               // [32:21] right_edge, [45:33] bottom_edge, [57:46] top_edge

  sprite_frame_sequencer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // shadow of the register file and of the animation state
  cfg_t                     sheet_cfg;
  logic [TICK_BITS_DEF-1:0] tick_now;
  int                       frame_now;
  logic                     heading_left;

  logic         tick_requests[$];   // restart bit of each pending input transaction
  sprite_view_t shown_frames[$];    // frames the block is yet to report
  int unsigned  mismatches;
  int unsigned  cycle_count;
  logic         steady;             // both sides keep going without gaps

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one tick or restart of the animation, returns the frame then shown
  function automatic sprite_view_t advance_sprite(input logic restart);
    sprite_view_t view;
    int           n;
    int           stepped;
    int unsigned  ivl;
    int unsigned  left;
    int unsigned  right;
    n = (sheet_cfg.frame_count == 0) ? 1 :
        (sheet_cfg.frame_count > MAX_FRAMES_DEF) ? int'(MAX_FRAMES_DEF) :
        int'(sheet_cfg.frame_count);
    ivl = (sheet_cfg.tick_interval == 0) ? 1 : sheet_cfg.tick_interval;
    view = '0;
    if (restart) begin
      tick_now = '0;
      view.frame_changed = 1'b1;
      if (sheet_cfg.mode == MODE_LEFT) begin
        frame_now = n - 1;
        heading_left = 1'b1;
      end else begin
        frame_now = 0;
        heading_left = 1'b0;
      end
    end else begin
      if (tick_now != TICK_TOP) tick_now = tick_now + 1'b1;
      if (tick_now >= ivl || tick_now == TICK_TOP) begin
        stepped = frame_now + (heading_left ? -1 : 1);
        tick_now = '0;
        view.frame_changed = 1'b1;
        if (stepped >= 0 && stepped < n) begin
          frame_now = stepped;
        end else if (sheet_cfg.mode == MODE_SWING) begin
          // bounce off the edge and step back the other way
          heading_left = !heading_left;
          stepped = stepped + (heading_left ? -2 : 2);
          if (stepped < 0) stepped = 0;
          if (stepped > n - 1) stepped = n - 1;
          frame_now = stepped;
        end else if (sheet_cfg.mode == MODE_LEFT) begin
          frame_now = n - 1;
          heading_left = 1'b1;
        end else begin
          frame_now = 0;
          heading_left = 1'b0;
        end
      end
    end
    // rectangle on the sheet, edges saturated
    left  = int'(sheet_cfg.first_left) +
            frame_now * (int'(sheet_cfg.frame_width) + int'(sheet_cfg.frame_gap));
    right = left + sheet_cfg.frame_width;
    view.frame_index = frame_now[7:0];
    view.left_edge   = (left > TEXEL_MAX) ? TEXEL_MAX : left[11:0];
    view.right_edge  = (right > TEXEL_MAX) ? TEXEL_MAX : right[11:0];
    view.bottom_edge = {1'b0, sheet_cfg.top_row} - {1'b0, sheet_cfg.frame_height};
    view.top_edge    = sheet_cfg.top_row;
    return view;
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // input side: predict on acceptance, then offer the next transaction
  always @(posedge clk_i) begin : driver_proc
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      shown_frames.push_back(advance_sprite(s_axis_tdata[0]));
    if (!s_axis_tvalid || s_axis_tready) begin
      if (tick_requests.size() != 0 && (steady || $urandom_range(0, 99) >= 26)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, tick_requests.pop_front()};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result side: random back-pressure, compare against oldest expectation
  always @(posedge clk_i) begin : monitor_proc
    sprite_view_t want;
    sprite_view_t got;
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 26);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.frame_index   = m_axis_tdata[7:0];
      got.frame_changed = m_axis_tdata[8];
      got.left_edge     = m_axis_tdata[20:9];
      got.right_edge    = m_axis_tdata[32:21];
      got.bottom_edge   = m_axis_tdata[45:33];
      got.top_edge      = m_axis_tdata[57:46];
      got.pad           = m_axis_tdata[63:58];
      if (shown_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: result expected none actual 0x%0h", $time, m_axis_tdata);
      end else begin
        want = shown_frames.pop_front();
        compare_field("frame_index", 16'(want.frame_index), 16'(got.frame_index));
        compare_field("frame_changed", 16'(want.frame_changed), 16'(got.frame_changed));
        compare_field("left_edge", 16'(want.left_edge), 16'(got.left_edge));
        compare_field("right_edge", 16'(want.right_edge), 16'(got.right_edge));
        compare_field("bottom_edge", 16'(want.bottom_edge), 16'(got.bottom_edge));
        compare_field("top_edge", 16'(want.top_edge), 16'(got.top_edge));
        compare_field("padding", 16'(want.pad), 16'(got.pad));
      end
    end
  end

  // register write, junk above the register width must be dropped
  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    logic [15:0] keep;
    case (idx)
      CFG_MODE:          keep = 16'h0003;
      CFG_TICK_INTERVAL: keep = 16'hFFFF;
      CFG_FRAME_COUNT:   keep = 16'h01FF;
      default:           keep = 16'h0FFF;
    endcase
    val = (val & keep) | (16'($urandom) & ~keep);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_MODE:          sheet_cfg.mode          = val[1:0];
      CFG_TICK_INTERVAL: sheet_cfg.tick_interval = val;
      CFG_FRAME_COUNT:   sheet_cfg.frame_count   = val[8:0];
      CFG_FIRST_LEFT:    sheet_cfg.first_left    = val[11:0];
      CFG_FRAME_WIDTH:   sheet_cfg.frame_width   = val[11:0];
      CFG_FRAME_GAP:     sheet_cfg.frame_gap     = val[11:0];
      CFG_TOP_ROW:       sheet_cfg.top_row       = val[11:0];
      default:           sheet_cfg.frame_height  = val[11:0];
    endcase
  endtask

  task automatic set_all(input logic [1:0] mode, input logic [15:0] interval,
                         input logic [8:0] frames, input logic [11:0] first_left,
                         input logic [11:0] width, input logic [11:0] gap,
                         input logic [11:0] top, input logic [11:0] height);
    write_reg(CFG_MODE, 16'(mode));
    write_reg(CFG_TICK_INTERVAL, interval);
    write_reg(CFG_FRAME_COUNT, 16'(frames));
    write_reg(CFG_FIRST_LEFT, 16'(first_left));
    write_reg(CFG_FRAME_WIDTH, 16'(width));
    write_reg(CFG_FRAME_GAP, 16'(gap));
    write_reg(CFG_TOP_ROW, 16'(top));
    write_reg(CFG_FRAME_HEIGHT, 16'(height));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic feed(input logic restart, input int count);
    for (int k = 0; k < count; k++) tick_requests.push_back(restart);
  endtask

  // wait for every transaction to come back and the input side to go idle
  task automatic settle();
    do @(negedge clk_i);
    while (tick_requests.size() != 0 || s_axis_tvalid || shown_frames.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [11:0] pick_texel();
    case ($urandom_range(0, 7))
      0:       return 12'd0;
      1:       return TEXEL_MAX;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [8:0] pick_frames();
    case ($urandom_range(0, 7))
      0:       return 9'($urandom);
      1:       return 9'd0;
      default: return 9'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [15:0] pick_interval();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 300));
      default: return 16'($urandom_range(0, 4));
    endcase
  endfunction

  // stimulus
  initial begin
    int restart_pct;
    int count;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_MODE;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    steady        = 1'b0;
    mismatches    = 0;
    cycle_count   = 0;
    sheet_cfg     = CFG_RESET;
    tick_now      = '0;
    frame_now     = 0;
    heading_left  = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: one frame, every tick wraps onto the same frame
    feed(1'b0, 1);
    feed(1'b1, 1);
    feed(1'b0, 1);
    settle();

    // one-frame swing holds frame 0, edges saturate, bottom goes negative
    set_all(MODE_SWING, 16'd1, 9'd1, TEXEL_MAX, TEXEL_MAX, TEXEL_MAX, 12'd0, TEXEL_MAX);
    feed(1'b1, 1);
    feed(1'b0, 2);
    settle();

    // step right every second tick over two frames
    set_all(MODE_RIGHT, 16'd2, 9'd2, 12'd0, 12'd0, 12'd0, TEXEL_MAX, 12'd0);
    feed(1'b1, 1);
    feed(1'b0, 4);
    settle();

    // step left, interval of zero acts as one
    set_all(MODE_LEFT, 16'd0, 9'd3, 12'd100, 12'd200, 12'd50, 12'd2000, 12'd3000);
    feed(1'b1, 1);
    feed(1'b0, 3);
    settle();

    // swing off both edges of three frames
    set_all(MODE_SWING, 16'd1, 9'd3, 12'd7, 12'd30, 12'd2, 12'd40, 12'd10);
    feed(1'b1, 1);
    feed(1'b0, 5);
    settle();

    // unused mode, then the frame count shrinks under the current frame
    set_all(MODE_UNUSED, 16'd1, 9'd8, 12'd1, 12'd500, 12'd20, 12'd300, 12'd301);
    feed(1'b1, 1);
    feed(1'b0, 3);
    settle();
    write_reg(CFG_FRAME_COUNT, 16'd2);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    feed(1'b0, 1);
    settle();

    // full sheet: run through frame 255 and past the end
    set_all(2'($urandom_range(0, 3)), 16'd1, 9'($urandom_range(256, 511)), pick_texel(),
            12'($urandom_range(0, 15)), 12'($urandom_range(0, 3)), pick_texel(),
            pick_texel());
    feed(1'b1, 1);
    feed(1'b0, 300);
    settle();

    // long interval over two frames; no gaps on either side here
    set_all(2'($urandom_range(0, 3)), 16'd37, 9'd2, pick_texel(), pick_texel(),
            pick_texel(), pick_texel(), pick_texel());
    steady <= 1'b1;
    feed(1'b1, 1);
    feed(1'b0, 160);
    settle();
    steady <= 1'b0;

    // random settings with random ticks and restarts
    for (int p = 0; p < 10; p++) begin
      set_all(2'($urandom_range(0, 3)), pick_interval(), pick_frames(), pick_texel(),
              pick_texel(), pick_texel(), pick_texel(), pick_texel());
      restart_pct = $urandom_range(0, 15);
      count = $urandom_range(40, 80);
      for (int k = 0; k < count; k++) feed($urandom_range(0, 99) < restart_pct, 1);
      settle();
    end

    repeat (6) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
